### src/adsr_envelope_voice_unit_assert.svh
// assertion macros shared by the envelope voice modules
`ifndef ADSR_ENVELOPE_VOICE_UNIT_ASSERT_SVH
`define ADSR_ENVELOPE_VOICE_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, off while in reset
`define AEVU_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off while in reset
`define AEVU_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/adsr_pkg.sv
// shared types, codes and constants of the envelope voice unit
`timescale 1ns / 1ps

package adsr_pkg;

	localparam int LEVEL_W   = 23;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 3;

	// level cap and default force-stop rate, Q7.16
	localparam logic [LEVEL_W-1:0] LEVEL_CAP     = LEVEL_W'(127 << 16);
	localparam logic [LEVEL_W-1:0] FORCE_DEFAULT = LEVEL_W'(6 << 16);

	typedef enum logic [2:0] {
		OP_TICK     = 3'd0,
		OP_NOTE_ON  = 3'd1,
		OP_NOTE_OFF = 3'd2,
		OP_CUT      = 3'd3,
		OP_STOP     = 3'd4
	} opcode_t;

	typedef enum logic [2:0] {
		VS_IDLE    = 3'd0,
		VS_ATTACK  = 3'd1,
		VS_DECAY   = 3'd2,
		VS_SUSTAIN = 3'd3,
		VS_RELEASE = 3'd4,
		VS_FORCE   = 3'd5
	} voice_stage_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ATTACK_RATE   = 3'd0,
		CFG_DECAY_RATE    = 3'd1,
		CFG_SUSTAIN_LEVEL = 3'd2,
		CFG_FADE_RATE     = 3'd3,
		CFG_RELEASE_RATE  = 3'd4,
		CFG_INITIAL_LEVEL = 3'd5
	} cfg_index_t;

	typedef enum logic [0:0] {
		CS_ACCEPT = 1'b0,
		CS_EXEC   = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic [6:0] note_velocity;
		logic [7:0] channel_volume;
	} in_item_t;

	typedef struct packed {
		logic [7:0]         voice_volume;
		logic [LEVEL_W-1:0] envelope_level;
		logic [2:0]         stage;
		logic               finished;
	} out_item_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic execute;
	} dp_cmd_t;

endpackage

### src/adsr_envelope_voice_unit.sv
// top level of the envelope voice unit: controller plus datapath
`timescale 1ns / 1ps

// One voice's ADSR envelope generator.
// Input channel in_valid/in_ready/in_item carries one request: tick, note_on,
// note_off, cut (force stop) or stop, with velocity and channel volume.
// Output channel out_valid/out_ready/out_item returns exactly one result per
// request: tick volume, envelope level (Q7.16), stage and finished flag.
// Configuration: cfg_we/cfg_index/cfg_data write one of six rate and level
// registers at the clock edge; write only while no request is in flight.
// A request is captured in the accept state and its result is written to
// the output register in the execute state that follows the capture.
// The controller's accept/execute sequence around the single envelope step
// unit takes no new request until the last one has been executed.
// The next request is accepted while a result still waits at the output;
// the execute step then waits until the output register is free.
// Reset (arst_n low) clears the configuration registers to zero, the voice to idle with
// level zero and held velocity zero, and empties the output register.

module adsr_envelope_voice_unit
	import adsr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_item
);

	dp_cmd_t cmd;

	// sequencing of accept and execute
	adsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// envelope state and arithmetic
	adsr_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.cmd       (cmd),
		.out_item  (out_item)
	);

endmodule

### src/adsr_ctrl.sv
// controller state machine of the envelope voice unit
`timescale 1ns / 1ps

module adsr_ctrl
	import adsr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	ctrl_state_t state_q, state_n;
	logic        out_valid_q;
	logic        slot_free;

	assign slot_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			CS_ACCEPT: begin
				if (in_valid) state_n = CS_EXEC;
			end
			CS_EXEC: begin
				if (slot_free) state_n = CS_ACCEPT;
			end
			default: state_n = CS_ACCEPT;
		endcase
	end

	// outputs
	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		case (state_q)
			CS_ACCEPT: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			CS_EXEC: begin
				cmd.execute = slot_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_ACCEPT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.execute) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`include "adsr_envelope_voice_unit_assert.svh"

	`AEVU_ASSERT_IMPL(a_valid_from_exec, $rose(out_valid_q), $past(state_q == CS_EXEC), "result appeared without execute")

endmodule

### src/adsr_datapath.sv
// envelope datapath: registers, level step and volume product
`timescale 1ns / 1ps

module adsr_datapath
	import adsr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  in_item_t             in_item,
	input  dp_cmd_t              cmd,
	output out_item_t            out_item
);

	// configuration registers
	logic [LEVEL_W-1:0] attack_rate_q, decay_rate_q, sustain_level_q;
	logic [LEVEL_W-1:0] release_rate_q, initial_level_q;
	logic signed [CFG_W-1:0] fade_rate_q;

	// voice state
	voice_stage_t       stage_q;
	logic [LEVEL_W-1:0] level_q;
	logic [6:0]         held_velocity_q;

	// captured request
	logic [2:0]  op_s1;
	logic [6:0]  vel_s1;
	logic [14:0] prod_s1;

	out_item_t out_q;

	// step results
	voice_stage_t       stage_n;
	logic [LEVEL_W-1:0] level_n;
	logic [6:0]         vel_n;
	logic [7:0]         volume_n;
	logic               fin_n;

	logic signed [LEVEL_W+1:0] level_ext, addend, sum, fade_ext;
	logic signed [LEVEL_W+1:0] cap_s, sus_s;
	logic [LEVEL_W-1:0]        sus_sat, init_sat, rel_rate;
	logic [21:0]               vol_full;

	localparam logic [1:0] ZX = 2'b00;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_rate_q   <= '0;
			decay_rate_q    <= '0;
			sustain_level_q <= '0;
			fade_rate_q     <= '0;
			release_rate_q  <= '0;
			initial_level_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ATTACK_RATE:   attack_rate_q   <= cfg_data[LEVEL_W-1:0];
				CFG_DECAY_RATE:    decay_rate_q    <= cfg_data[LEVEL_W-1:0];
				CFG_SUSTAIN_LEVEL: sustain_level_q <= cfg_data[LEVEL_W-1:0];
				CFG_FADE_RATE:     fade_rate_q     <= $signed(cfg_data);
				CFG_RELEASE_RATE:  release_rate_q  <= cfg_data[LEVEL_W-1:0];
				CFG_INITIAL_LEVEL: initial_level_q <= cfg_data[LEVEL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// capture request and first volume product
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_s1   <= in_item.opcode;
			vel_s1  <= in_item.note_velocity;
			prod_s1 <= 15'(in_item.channel_volume) * 15'(held_velocity_q);
		end
	end

	// saturated registers and the step addend
	always_comb begin
		sus_sat   = (sustain_level_q > LEVEL_CAP) ? LEVEL_CAP : sustain_level_q;
		init_sat  = (initial_level_q > LEVEL_CAP) ? LEVEL_CAP : initial_level_q;
		rel_rate  = (stage_q == VS_FORCE && release_rate_q == '0) ? FORCE_DEFAULT
			: release_rate_q;
		level_ext = $signed({ZX, level_q});
		cap_s     = $signed({ZX, LEVEL_CAP});
		sus_s     = $signed({ZX, sus_sat});
		fade_ext  = {fade_rate_q[CFG_W-1], fade_rate_q};
		case (stage_q)
			VS_ATTACK:  addend = $signed({ZX, attack_rate_q});
			VS_DECAY:   addend = -$signed({ZX, decay_rate_q});
			VS_SUSTAIN: addend = -fade_ext;
			VS_RELEASE: addend = -$signed({ZX, rel_rate});
			VS_FORCE:   addend = -$signed({ZX, rel_rate});
			default:    addend = '0;
		endcase
		sum      = level_ext + addend;
		vol_full = 22'(prod_s1) * 22'(level_q[LEVEL_W-1:16]);
	end

	// envelope step for the captured request
	always_comb begin
		stage_n  = stage_q;
		level_n  = level_q;
		vel_n    = held_velocity_q;
		volume_n = '0;
		fin_n    = 1'b0;
		case (op_s1)
			OP_TICK: begin
				if (stage_q != VS_IDLE) begin
					volume_n = vol_full[21:14];
					case (stage_q)
						VS_ATTACK: begin
							if (sum >= cap_s) begin
								level_n = LEVEL_CAP;
								stage_n = VS_DECAY;
							end else begin
								level_n = sum[LEVEL_W-1:0];
							end
						end
						VS_DECAY: begin
							if (sum <= sus_s) begin
								level_n = sus_sat;
								stage_n = VS_SUSTAIN;
							end else begin
								level_n = sum[LEVEL_W-1:0];
							end
						end
						VS_SUSTAIN: begin
							if (sum >= cap_s) begin
								level_n = LEVEL_CAP;
							end else if (sum <= 0) begin
								level_n = '0;
								fin_n   = 1'b1;
							end else begin
								level_n = sum[LEVEL_W-1:0];
							end
						end
						VS_RELEASE, VS_FORCE: begin
							if (sum <= 0) begin
								level_n = '0;
								fin_n   = 1'b1;
							end else begin
								level_n = sum[LEVEL_W-1:0];
							end
						end
						default: begin
						end
					endcase
					if (fin_n) stage_n = VS_IDLE;
				end
			end
			OP_NOTE_ON: begin
				level_n = init_sat;
				vel_n   = vel_s1;
				stage_n = VS_ATTACK;
			end
			OP_NOTE_OFF: begin
				if (stage_q != VS_IDLE) stage_n = VS_RELEASE;
			end
			OP_CUT: begin
				if (stage_q != VS_IDLE) stage_n = VS_FORCE;
			end
			OP_STOP: begin
				stage_n = VS_IDLE;
			end
			default: begin
			end
		endcase
	end

	// voice state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q         <= VS_IDLE;
			level_q         <= '0;
			held_velocity_q <= '0;
		end else if (cmd.execute) begin
			stage_q         <= stage_n;
			level_q         <= level_n;
			held_velocity_q <= vel_n;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			out_q.voice_volume   <= volume_n;
			out_q.envelope_level <= level_n;
			out_q.stage          <= stage_n;
			out_q.finished       <= fin_n;
		end
	end

	assign out_item = out_q;

	`include "adsr_envelope_voice_unit_assert.svh"

	`AEVU_ASSERT_IMPL(a_level_cap, 1'b1, level_q <= LEVEL_CAP, "level above cap")
	`AEVU_ASSERT_NEXT(a_fin_idle, cmd.execute, !out_q.finished || (out_q.stage == VS_IDLE && out_q.envelope_level == '0), "finished without idle zero level")
	`AEVU_ASSERT_NEXT(a_vol_tick, cmd.execute && op_s1 != OP_TICK, out_q.voice_volume == '0 && !out_q.finished, "volume or finished on non-tick")

endmodule

### sim/adsr_envelope_voice_unit_test.sv
// self-checking testbench of the envelope voice unit with its own envelope predictor
`timescale 1ns / 1ps

module adsr_envelope_voice_unit_test;
	import adsr_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int STALL_LEN   = 60;
	localparam int PHASES      = 7;
	localparam int PHASE_ITEMS = 80;

	// opcodes the block treats as no-ops
	localparam logic [2:0] OP_SPARE_5 = 3'd5;
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	localparam out_item_t IDLE_ZERO = '{8'd0, 23'd0, VS_IDLE, 1'b0};
	localparam out_item_t ON_AT_CAP = '{8'd0, LEVEL_CAP, VS_ATTACK, 1'b0};

	typedef struct {
		in_item_t  req;
		bit        typed;
		out_item_t want;
	} opening_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	in_item_t             in_item;
	logic                 out_valid;
	logic                 out_ready;
	out_item_t            out_item;

	// register copies and voice state of the predictor
	logic [LEVEL_W-1:0]  attack_shadow  = '0;
	logic [LEVEL_W-1:0]  decay_shadow   = '0;
	logic [LEVEL_W-1:0]  sustain_shadow = '0;
	logic signed [23:0]  fade_shadow    = '0;
	logic [LEVEL_W-1:0]  release_shadow = '0;
	logic [LEVEL_W-1:0]  initial_shadow = '0;
	voice_stage_t        vstage         = VS_IDLE;
	logic [LEVEL_W-1:0]  env_lvl        = '0;
	logic [6:0]          held_vel       = '0;

	out_item_t pending_results[$];
	out_item_t oldest;
	bit        row_typed;
	out_item_t row_want;
	int        errors;
	int        sent;
	int        quiet;
	int        sender_idle_pct;
	int        recv_idle_pct;
	bit        stall_req;
	int        stall_left;

	// opening requests: idle no-ops, saturated note_on, every stage entered
	opening_row_t opening_rows [21] = '{
		'{'{OP_TICK,     7'd127, 8'd255}, 1'b1, IDLE_ZERO},
		'{'{OP_NOTE_OFF, 7'd127, 8'd255}, 1'b1, IDLE_ZERO},
		'{'{OP_CUT,      7'd0,   8'd0},   1'b1, IDLE_ZERO},
		'{'{OP_STOP,     7'd127, 8'd0},   1'b1, IDLE_ZERO},
		'{'{OP_SPARE_5,  7'd127, 8'd255}, 1'b1, IDLE_ZERO},
		'{'{OP_SPARE_6,  7'd0,   8'd255}, 1'b1, IDLE_ZERO},
		'{'{OP_SPARE_7,  7'd127, 8'd255}, 1'b1, IDLE_ZERO},
		'{'{OP_NOTE_ON,  7'd127, 8'd0},   1'b1, ON_AT_CAP},
		'{'{OP_TICK,     7'd0,   8'd255}, 1'b0, '0},
		'{'{OP_TICK,     7'd0,   8'd255}, 1'b0, '0},
		'{'{OP_TICK,     7'd85,  8'd128}, 1'b0, '0},
		'{'{OP_NOTE_ON,  7'd0,   8'd255}, 1'b1, ON_AT_CAP},
		'{'{OP_TICK,     7'd127, 8'd255}, 1'b0, '0},
		'{'{OP_NOTE_OFF, 7'd0,   8'd0},   1'b1, '{8'd0, LEVEL_CAP, VS_RELEASE, 1'b0}},
		'{'{OP_TICK,     7'd0,   8'd255}, 1'b0, '0},
		'{'{OP_NOTE_ON,  7'd127, 8'd85},  1'b1, ON_AT_CAP},
		'{'{OP_CUT,      7'd42,  8'd170}, 1'b1, '{8'd0, LEVEL_CAP, VS_FORCE, 1'b0}},
		'{'{OP_TICK,     7'd0,   8'd255}, 1'b0, '0},
		'{'{OP_SPARE_5,  7'd0,   8'd0},   1'b0, '0},
		'{'{OP_STOP,     7'd0,   8'd0},   1'b0, '0},
		'{'{OP_TICK,     7'd127, 8'd255}, 1'b0, '0}
	};

	adsr_envelope_voice_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [LEVEL_W-1:0] under_cap(logic [LEVEL_W-1:0] v);
		return (v > LEVEL_CAP) ? LEVEL_CAP : v;
	endfunction

	// envelope predictor: applies one request to the voice state, returns its result
	function automatic out_item_t envelope_step(in_item_t req);
		out_item_t   res;
		longint      lvl_next;
		longint      step_down;
		int unsigned loud;
		logic        done;
		res  = '0;
		done = 1'b0;
		case (req.opcode)
		OP_TICK: begin
			if (vstage != VS_IDLE) begin
				lvl_next = longint'(env_lvl);
				loud = (32'(req.channel_volume) * 32'(held_vel) * 32'(env_lvl[22:16])) >> 14;
				res.voice_volume = loud[7:0];
				case (vstage)
				VS_ATTACK: begin
					lvl_next += longint'(attack_shadow);
					if (lvl_next >= longint'(LEVEL_CAP)) begin
						lvl_next = longint'(LEVEL_CAP);
						vstage   = VS_DECAY;
					end
				end
				VS_DECAY: begin
					lvl_next -= longint'(decay_shadow);
					if (lvl_next <= longint'(under_cap(sustain_shadow))) begin
						lvl_next = longint'(under_cap(sustain_shadow));
						vstage   = VS_SUSTAIN;
					end
				end
				VS_SUSTAIN: begin
					lvl_next -= longint'(fade_shadow);
					if (lvl_next >= longint'(LEVEL_CAP)) begin
						lvl_next = longint'(LEVEL_CAP);
					end else if (lvl_next <= 0) begin
						lvl_next = 0;
						done     = 1'b1;
					end
				end
				VS_RELEASE, VS_FORCE: begin
					step_down = longint'(release_shadow);
					if (vstage == VS_FORCE && step_down == 0) step_down = longint'(FORCE_DEFAULT);
					lvl_next -= step_down;
					if (lvl_next <= 0) begin
						lvl_next = 0;
						done     = 1'b1;
					end
				end
				default: ;
				endcase
				if (lvl_next > longint'(LEVEL_CAP)) lvl_next = longint'(LEVEL_CAP);
				if (lvl_next < 0) lvl_next = 0;
				env_lvl = lvl_next[LEVEL_W-1:0];
				if (done) vstage = VS_IDLE;
			end
		end
		OP_NOTE_ON: begin
			env_lvl  = under_cap(initial_shadow);
			held_vel = req.note_velocity;
			vstage   = VS_ATTACK;
		end
		OP_NOTE_OFF: begin
			if (vstage != VS_IDLE) vstage = VS_RELEASE;
		end
		OP_CUT: begin
			if (vstage != VS_IDLE) vstage = VS_FORCE;
		end
		OP_STOP: begin
			vstage = VS_IDLE;
		end
		default: ;
		endcase
		res.envelope_level = env_lvl;
		res.stage          = vstage;
		res.finished       = done;
		return res;
	endfunction

	// prediction on accepted requests, checking of accepted results, watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				if (row_typed) begin
					void'(envelope_step(in_item));
					pending_results.push_back(row_want);
				end else begin
					pending_results.push_back(envelope_step(in_item));
				end
			end
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("result with nothing expected: %h", out_item);
					errors++;
				end else begin
					oldest = pending_results.pop_front();
					if (out_item.voice_volume !== oldest.voice_volume) begin
						$error("voice_volume: expected %0d, got %0d",
							oldest.voice_volume, out_item.voice_volume);
						errors++;
					end
					if (out_item.envelope_level !== oldest.envelope_level) begin
						$error("envelope_level: expected %h, got %h",
							oldest.envelope_level, out_item.envelope_level);
						errors++;
					end
					if (out_item.stage !== oldest.stage) begin
						$error("stage: expected %0d, got %0d", oldest.stage, out_item.stage);
						errors++;
					end
					if (out_item.finished !== oldest.finished) begin
						$error("finished: expected %0d, got %0d",
							oldest.finished, out_item.finished);
						errors++;
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
			else quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// result side: random stalls plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_req) begin
				stall_req  = 1'b0;
				stall_left = STALL_LEN;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	task automatic put_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
		CFG_ATTACK_RATE:   attack_shadow  = val[LEVEL_W-1:0];
		CFG_DECAY_RATE:    decay_shadow   = val[LEVEL_W-1:0];
		CFG_SUSTAIN_LEVEL: sustain_shadow = val[LEVEL_W-1:0];
		CFG_FADE_RATE:     fade_shadow    = val;
		CFG_RELEASE_RATE:  release_shadow = val[LEVEL_W-1:0];
		CFG_INITIAL_LEVEL: initial_shadow = val[LEVEL_W-1:0];
		default: ;
		endcase
		@(negedge clk);
	endtask

	// write all six registers; only called with no request in flight
	task automatic load_regs(logic [LEVEL_W-1:0] atk, logic [LEVEL_W-1:0] dcy,
			logic [LEVEL_W-1:0] sus, logic [CFG_W-1:0] fade,
			logic [LEVEL_W-1:0] rel, logic [LEVEL_W-1:0] init_lvl);
		put_reg(CFG_ATTACK_RATE, CFG_W'(atk));
		put_reg(CFG_DECAY_RATE, CFG_W'(dcy));
		put_reg(CFG_SUSTAIN_LEVEL, CFG_W'(sus));
		put_reg(CFG_FADE_RATE, fade);
		put_reg(CFG_RELEASE_RATE, CFG_W'(rel));
		put_reg(CFG_INITIAL_LEVEL, CFG_W'(init_lvl));
		cfg_we <= 1'b0;
	endtask

	function automatic logic [LEVEL_W-1:0] rand_rate();
		case ($urandom_range(0, 9))
		0: return '0;
		1: return 23'h7FFFFF;
		2: return LEVEL_CAP;
		3, 4: return LEVEL_W'($urandom_range(1, 'hFFFF));
		default: return LEVEL_W'($urandom_range('h10000, 'h400000));
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] rand_fade();
		case ($urandom_range(0, 6))
		0: return '0;
		1: return 24'h7FFFFF;
		2: return 24'h800000;
		3, 4: return CFG_W'($urandom_range(1, 'h80000));
		default: return CFG_W'(0 - $urandom_range(1, 'h80000));
		endcase
	endfunction

	function automatic in_item_t req_of(logic [2:0] op);
		in_item_t r;
		r.opcode         = op;
		r.note_velocity  = 7'($urandom_range(0, 127));
		r.channel_volume = 8'($urandom_range(0, 255));
		return r;
	endfunction

	// offer one request and hold it until accepted; starts and ends at a falling edge
	task automatic send_req(in_item_t req, bit typed, out_item_t want);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		in_item   <= req;
		row_typed = typed;
		row_want  = want;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		sent++;
	endtask

	task automatic tick_or_noise();
		if ($urandom_range(0, 99) < 8) send_req(req_of(3'($urandom_range(0, 7))), 1'b0, '0);
		else send_req(req_of(OP_TICK), 1'b0, '0);
	endtask

	// one note: note_on, held ticks, usually an ending, then up to 48 ticks until the voice goes idle
	task automatic play_phrase();
		int ending;
		int tail;
		if ($urandom_range(0, 9) == 0) send_req(req_of(3'($urandom_range(0, 7))), 1'b0, '0);
		send_req(req_of(OP_NOTE_ON), 1'b0, '0);
		repeat ($urandom_range(1, 30)) tick_or_noise();
		ending = $urandom_range(0, 9);
		if (ending < 5) send_req(req_of(OP_NOTE_OFF), 1'b0, '0);
		else if (ending < 8) send_req(req_of(OP_CUT), 1'b0, '0);
		else if (ending == 8) send_req(req_of(OP_STOP), 1'b0, '0);
		for (tail = 0; tail < 48 && vstage != VS_IDLE; tail++) tick_or_noise();
	endtask

	// stop offering and wait until every expected result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending_results.size() != 0);
	endtask

	initial begin
		int goal;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = CFG_ATTACK_RATE;
		cfg_data        = '0;
		in_valid        = 1'b0;
		in_item         = '0;
		row_typed       = 1'b0;
		row_want        = '0;
		errors          = 0;
		sent            = 0;
		quiet           = 0;
		stall_req       = 1'b0;
		stall_left      = 0;
		sender_idle_pct = 11;
		recv_idle_pct   = 79;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// saturating registers, most negative fade, zero release
		load_regs(23'h7FFFFF, 23'h10000, 23'h7FFFFF, 24'h800000, 23'h0, 23'h7FFFFF);
		for (int i = 0; i < $size(opening_rows); i++)
			send_req(opening_rows[i].req, opening_rows[i].typed, opening_rows[i].want);
		drain_results();

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph < 2) begin
				sender_idle_pct = 11;
				recv_idle_pct   = 79;
			end else if (ph < 4) begin
				sender_idle_pct = 79;
				recv_idle_pct   = 11;
			end else begin
				sender_idle_pct = 0;
				recv_idle_pct   = 0;
			end
			if (ph == 0) load_regs('0, '0, '0, '0, '0, '0);
			else if (ph == 1) load_regs(23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 24'h7FFFFF,
				23'h7FFFFF, 23'h7FFFFF);
			else load_regs(rand_rate(), rand_rate(), rand_rate(), rand_fade(),
				rand_rate(), rand_rate());
			// long result-side hold-off while requests keep coming
			if (ph == 4) stall_req = 1'b1;
			goal = sent + PHASE_ITEMS;
			while (sent < goal) begin
				play_phrase();
				// sender pause until the block is empty, mid-phase
				if (ph == 5 && sent >= goal - PHASE_ITEMS / 2 && sent < goal - PHASE_ITEMS / 4)
					drain_results();
			end
			drain_results();
		end

		repeat (8) @(posedge clk);
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule
